FILE: rtl/assert_macros.svh
// assertion macros used by hufd_walk
// each macro expects clk and arst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define HUFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define HUFD_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |-> prop) else $error(msg);

// next-cycle implication
`define HUFD_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> prop) else $error(msg);

`endif

FILE: rtl/hufd_pkg.sv
// types and constants for the huffman tree byte decoder
// no dependencies
package hufd_pkg;

	localparam int TREE_NODES = 255;
	localparam int NODE_AW    = $clog2(TREE_NODES);
	localparam int NODE_W     = 8;
	localparam int CHILD_W    = 9;
	localparam int LEN_W      = 24;
	localparam int BYTE_W     = 8;
	localparam int SYM_W      = 8;
	localparam int BIT_CNT_W  = $clog2(BYTE_W);

	localparam logic [NODE_W-1:0] HEAD_NODE = 8'd254;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_DATA  = 2'd2
	} op_t;

	typedef struct packed {
		logic load;
		logic start;
		logic data;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node_index;
		logic [CHILD_W-1:0] zero_child;
		logic [CHILD_W-1:0] one_child;
		logic [LEN_W-1:0]   out_length;
		logic [BYTE_W-1:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
		logic             run_end;
		logic             chunk_end;
	} emit_t;

endpackage

FILE: rtl/hufd_walk.sv
// tree store and bit-serial tree walk, one code bit per cycle while the output does not stall the walk
// depends on hufd_pkg and assert_macros.svh
`include "assert_macros.svh"

module hufd_walk import hufd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  item_t item,
	input  logic  out_free,
	output logic  in_ready,
	output emit_t emit
);

	typedef enum logic [1:0] {
		IDLE_S,
		STEP_S,
		FLUSH_S
	} state_t;

	state_t                 state_q;
	logic [NODE_W-1:0]      walk_q;
	logic [LEN_W-1:0]       left_q;
	logic [BYTE_W-1:0]      sh_q;
	logic [BIT_CNT_W-1:0]   cnt_q;
	logic                   pend_valid_q;
	logic [SYM_W-1:0]       pend_sym_q;
	logic                   pend_chunk_q;
	logic [2*CHILD_W-1:0]   rd_q;
	logic                   rd_zero_q;
	logic [2*CHILD_W-1:0]   mem [TREE_NODES];

	logic [2*CHILD_W-1:0]   node;
	logic [CHILD_W-1:0]     child;
	logic                   leaf;
	logic                   last_sym;
	logic                   stall;
	logic                   advance;
	logic                   flush_go;
	logic                   byte_go;
	logic [NODE_W-1:0]      next_node;
	logic [NODE_W-1:0]      rd_node;

	always_comb begin
		node      = rd_zero_q ? '0 : rd_q;
		child     = sh_q[0] ? node[2*CHILD_W-1:CHILD_W] : node[CHILD_W-1:0];
		leaf      = !child[CHILD_W-1];
		last_sym  = (left_q == LEN_W'(1));
		stall     = leaf && pend_valid_q && !out_free;
		advance   = (state_q == STEP_S) && !stall;
		next_node = leaf ? HEAD_NODE : child[NODE_W-1:0];
		rd_node   = advance ? next_node : walk_q;
		flush_go  = (state_q == FLUSH_S) && (!pend_valid_q || out_free);
		in_ready  = (state_q == IDLE_S) || flush_go;
		byte_go   = cmd.data && (left_q != '0);

		emit.valid     = (advance && leaf && pend_valid_q) || (flush_go && pend_valid_q);
		emit.symbol    = pend_sym_q;
		emit.run_end   = (state_q == FLUSH_S);
		emit.chunk_end = (state_q == FLUSH_S) && pend_chunk_q;
	end

	// tree store, read data registered
	always_ff @(posedge clk) begin
		if (cmd.load && (item.node_index < NODE_W'(TREE_NODES))) begin
			mem[item.node_index[NODE_AW-1:0]] <= {item.one_child, item.zero_child};
		end
		rd_q      <= mem[rd_node[NODE_AW-1:0]];
		rd_zero_q <= (rd_node >= NODE_W'(TREE_NODES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE_S;
			walk_q       <= HEAD_NODE;
			left_q       <= '0;
			sh_q         <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			pend_chunk_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE_S: begin
					if (byte_go) begin
						state_q <= STEP_S;
					end
				end
				STEP_S: begin
					if (!stall) begin
						sh_q  <= sh_q >> 1;
						cnt_q <= cnt_q + 1'b1;
						if (leaf) begin
							left_q       <= left_q - LEN_W'(1);
							walk_q       <= HEAD_NODE;
							pend_valid_q <= 1'b1;
							pend_sym_q   <= child[SYM_W-1:0];
							pend_chunk_q <= last_sym;
						end else begin
							walk_q <= child[NODE_W-1:0];
						end
						if ((leaf && last_sym) || (cnt_q == '1)) begin
							state_q <= FLUSH_S;
						end
					end
				end
				FLUSH_S: begin
					if (flush_go) begin
						pend_valid_q <= 1'b0;
						state_q      <= byte_go ? STEP_S : IDLE_S;
					end
				end
				default: begin
					state_q <= IDLE_S;
				end
			endcase

			if (cmd.start) begin
				left_q <= item.out_length;
				walk_q <= HEAD_NODE;
			end
			if (byte_go) begin
				sh_q  <= item.data_byte;
				cnt_q <= '0;
			end
		end
	end

	`HUFD_ASSERT(a_emit_room, !emit.valid || out_free, "symbol emitted into a full output stage")
	`HUFD_ASSERT_IMPL(a_chunk_flush, pend_valid_q && pend_chunk_q, state_q == FLUSH_S,
		"chunk end symbol held outside flush")
	`HUFD_ASSERT_IMPL(a_step_live, state_q == STEP_S, left_q != '0, "walking with no symbols left")
	`HUFD_ASSERT_NEXT(a_stall_hold, (state_q == STEP_S) && stall,
		$stable(cnt_q) && $stable(sh_q), "bit consumed during stall")
	`HUFD_ASSERT_NEXT(a_leaf_count, advance && leaf,
		left_q == $past(left_q) - LEN_W'(1), "symbol count not decremented")

endmodule

FILE: rtl/huffman_tree_byte_decoder_unit.sv
// huffman tree byte decoder: load and start are taken while idle or as a flush ends;
// a data byte is walked in up to eight tree steps, one per code bit, through the single
// read port of the tree store, then flushed; fewer when the chunk ends inside the byte;
// a byte is dropped when no chunk is active; a full output stalls the walk at a leaf
// a byte's last symbol is held until the flush state passes it to the output register
// asynchronous active-low reset clears the walk, the symbol count and the output stage
module huffman_tree_byte_decoder_unit import hufd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// node_index, zero_child, one_child, out_length, data_byte, zero pad
	input  logic [63:0] s_tdata,
	// op
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// symbol
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	// chunk_end
	output logic        m_tuser
);

	logic             in_ready;
	cmd_t             cmd;
	item_t            item;
	emit_t            emit;
	logic             out_free;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_last_q;
	logic             out_chunk_q;

	always_comb begin
		cmd = '0;
		if (s_tvalid && in_ready) begin
			unique case (s_tuser)
				OP_LOAD:  cmd.load  = 1'b1;
				OP_START: cmd.start = 1'b1;
				OP_DATA:  cmd.data  = 1'b1;
				default:  cmd       = '0;
			endcase
		end
		item.node_index = s_tdata[7:0];
		item.zero_child = s_tdata[16:8];
		item.one_child  = s_tdata[25:17];
		item.out_length = s_tdata[49:26];
		item.data_byte  = s_tdata[57:50];
	end

	assign s_tready = in_ready;
	assign out_free = !out_valid_q || m_tready;

	hufd_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.out_free (out_free),
		.in_ready (in_ready),
		.emit     (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_sym_q   <= emit.symbol;
			out_last_q  <= emit.run_end;
			out_chunk_q <= emit.chunk_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_chunk_q;

endmodule
